[rtl/multilinear_word_hash_macros.svh]
// assertion helpers used by the checker file
`ifndef MULTILINEAR_WORD_HASH_MACROS_SVH
`define MULTILINEAR_WORD_HASH_MACROS_SVH

// same-cycle implication, off while reset is low
`define MWH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define MWH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mwh_pkg.sv]
package mwh_pkg;

  // hash geometry
  localparam int MaxWords  = 1023;
  localparam int KeyStride = 5;
  localparam int KeyRows   = MaxWords + 1;
  localparam int KeyDepth  = KeyRows * KeyStride;
  localparam int RowW      = $clog2(KeyRows);
  localparam int BankW     = $clog2(KeyStride);
  localparam int AccWords  = 4;
  localparam int AccIdxW   = $clog2(AccWords);

  // field widths
  localparam int AddrW = 13;
  localparam int KeyW  = 64;
  localparam int HalfW = KeyW / 2;
  localparam int MsgW  = 32;
  localparam int VbW   = 3;
  localparam int PosW  = 10;

  // divide-by-stride through a reciprocal, exact for every address of AddrW bits
  localparam int RecipShift = 15;
  localparam int RecipStride = ((1 << RecipShift) + KeyStride - 1) / KeyStride;
  localparam int ProdW = 2 * AddrW;

  // message byte masks
  localparam logic [MsgW-1:0] MsgMaskFull = 32'hFFFF_FFFF;
  localparam logic [MsgW-1:0] MsgMask1    = 32'h0000_00FF;
  localparam logic [MsgW-1:0] MsgMask2    = 32'h0000_FFFF;
  localparam logic [MsgW-1:0] MsgMask3    = 32'h00FF_FFFF;

  // slave tdata layout
  localparam int SAddrLsb  = 0;
  localparam int SKeyLsb   = SAddrLsb + AddrW;
  localparam int SMsgLsb   = SKeyLsb + KeyW;
  localparam int SVbLsb    = SMsgLsb + MsgW;
  localparam int SFirstLsb = SVbLsb + VbW;
  localparam int SUsedW    = SFirstLsb + 1;
  localparam int SDataW    = ((SUsedW + 7) / 8) * 8;

  // master tdata layout
  localparam int MCntLsb = AccWords * KeyW;
  localparam int MOvfLsb = MCntLsb + PosW;
  localparam int MUsedW  = MOvfLsb + 1;
  localparam int MDataW  = ((MUsedW + 7) / 8) * 8;

  typedef enum logic {
    KIND_KEY  = 1'b0,
    KIND_HASH = 1'b1
  } kind_e;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic               hash;
    logic               hen;
    logic               first;
    logic               last;
    logic [PosW-1:0]    pos;
    logic               ovf;
    logic               kwr;
    logic [AccIdxW-1:0] kidx;
    logic [KeyW-1:0]    kdata;
  } side_t;

endpackage

[rtl/mwh_ram.sv]
module mwh_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/multilinear_word_hash.sv]
// channel   dir  signals                          content
// s_axis    in   tvalid tready tdata tuser tlast  key write or message word
// m_axis    out  tvalid tready tdata              hash words, word count, overflow
//
// one item per cycle unless the output stalls; a result is registered after stage 4
// the key store is five banks, one per key word of a position, so all five key
// words of a position come from a single read of the banks
// reset clears accumulator, position, overflow flag and all valid bits
// a stalled output backs up the pipeline stage by stage; bubbles are squeezed out
module multilinear_word_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // key_address, key_data, message_word, valid_bytes, first_word, zero pad
  input  logic [mwh_pkg::SDataW-1:0]  s_axis_tdata,
  // kind
  input  logic                        s_axis_tuser,
  // last_word
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hash_word0, hash_word1, hash_word2, hash_word3, word_count, overflow, zero pad
  output logic [mwh_pkg::MDataW-1:0]  m_axis_tdata
);

  // input fields
  logic [mwh_pkg::AddrW-1:0] in_addr;
  logic [mwh_pkg::KeyW-1:0]  in_key;
  logic [mwh_pkg::MsgW-1:0]  in_msg;
  logic [mwh_pkg::VbW-1:0]   in_vb;
  logic                      in_first;
  logic                      is_hash;
  logic                      s_acc;

  assign in_addr  = s_axis_tdata[mwh_pkg::SAddrLsb +: mwh_pkg::AddrW];
  assign in_key   = s_axis_tdata[mwh_pkg::SKeyLsb +: mwh_pkg::KeyW];
  assign in_msg   = s_axis_tdata[mwh_pkg::SMsgLsb +: mwh_pkg::MsgW];
  assign in_vb    = s_axis_tdata[mwh_pkg::SVbLsb +: mwh_pkg::VbW];
  assign in_first = s_axis_tdata[mwh_pkg::SFirstLsb];
  assign is_hash  = (mwh_pkg::kind_e'(s_axis_tuser) == mwh_pkg::KIND_HASH);
  assign s_acc    = s_axis_tvalid & s_axis_tready;

  // position and overflow tracking
  logic [mwh_pkg::PosW-1:0] pos_q, pos_base, pos_nxt;
  logic                     ovf_q, ovf_base, ovf_nxt, in_cap;

  always_comb begin
    pos_base = in_first ? '0 : pos_q;
    ovf_base = in_first ? 1'b0 : ovf_q;
    in_cap   = pos_base < mwh_pkg::PosW'(mwh_pkg::MaxWords);
    pos_nxt  = in_cap ? (pos_base + mwh_pkg::PosW'(1)) : pos_base;
    ovf_nxt  = ovf_base | ~in_cap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else if (s_acc && is_hash) begin
      pos_q <= pos_nxt;
      ovf_q <= ovf_nxt;
    end
  end

  // message masking
  logic [mwh_pkg::MsgW-1:0] msg_mask;

  always_comb begin
    case (in_vb)
      3'd0:    msg_mask = '0;
      3'd1:    msg_mask = mwh_pkg::MsgMask1;
      3'd2:    msg_mask = mwh_pkg::MsgMask2;
      3'd3:    msg_mask = mwh_pkg::MsgMask3;
      default: msg_mask = mwh_pkg::MsgMaskFull;
    endcase
  end

  // key address split into row and bank
  logic [mwh_pkg::ProdW-1:0] addr_prod;
  logic [mwh_pkg::RowW-1:0]  wr_row;
  logic [mwh_pkg::AddrW-1:0] wr_rem;
  logic [mwh_pkg::BankW-1:0] wr_bank;
  logic                      addr_ok;
  logic [mwh_pkg::RowW-1:0]  rd_row;

  always_comb begin
    addr_prod = mwh_pkg::ProdW'(in_addr) * mwh_pkg::ProdW'(mwh_pkg::RecipStride);
    wr_row    = addr_prod[mwh_pkg::RecipShift +: mwh_pkg::RowW];
    wr_rem    = in_addr - mwh_pkg::AddrW'(wr_row * mwh_pkg::KeyStride);
    wr_bank   = wr_rem[mwh_pkg::BankW-1:0];
    addr_ok   = in_addr < mwh_pkg::AddrW'(mwh_pkg::KeyDepth);
    rd_row    = mwh_pkg::RowW'(pos_base + mwh_pkg::PosW'(1));
  end

  // banked key store
  logic [mwh_pkg::KeyW-1:0] key_rd [mwh_pkg::KeyStride];

  for (genvar b = 0; b < mwh_pkg::KeyStride; b++) begin : g_bank
    mwh_ram #(
      .Width (mwh_pkg::KeyW),
      .Depth (mwh_pkg::KeyRows)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (s_acc && !is_hash && addr_ok && (wr_bank == mwh_pkg::BankW'(b))),
      .waddr_i (wr_row),
      .wdata_i (in_key),
      .re_i    (s_acc && is_hash),
      .raddr_i (rd_row),
      .rdata_o (key_rd[b])
    );
  end

  // stage control
  logic v1_q, v2_q, v3_q, v4_q, mv_q;
  logic rdy1, rdy2, rdy3, rdy4, drain4, res4;
  mwh_pkg::side_t sd0, sd1_q, sd2_q, sd3_q, sd4_q;

  always_comb begin
    sd0.hash  = is_hash;
    sd0.hen   = is_hash & in_cap;
    sd0.first = in_first;
    sd0.last  = s_axis_tlast;
    sd0.pos   = pos_nxt;
    sd0.ovf   = ovf_nxt;
    sd0.kwr   = !is_hash && (in_addr < mwh_pkg::AddrW'(mwh_pkg::AccWords));
    sd0.kidx  = in_addr[mwh_pkg::AccIdxW-1:0];
    sd0.kdata = in_key;
  end

  // each stage moves when its successor has room
  always_comb begin
    res4          = sd4_q.hash & sd4_q.last;
    drain4        = v4_q & (~res4 | ~mv_q | m_axis_tready);
    rdy4          = ~v4_q | drain4;
    rdy3          = ~v3_q | rdy4;
    rdy2          = ~v2_q | rdy3;
    rdy1          = ~v1_q | rdy2;
    s_axis_tready = rdy1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_acc;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // stage 1: key words arrive from the banks
  logic [mwh_pkg::MsgW-1:0] msg1_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      sd1_q  <= sd0;
      msg1_q <= in_msg & msg_mask;
    end
  end

  // stage 2: 32x32 partial products
  logic [mwh_pkg::KeyW-1:0]  plo_q [mwh_pkg::AccWords];
  logic [mwh_pkg::KeyW-1:0]  phi_q [mwh_pkg::AccWords];
  logic [mwh_pkg::HalfW-1:0] plo4_q;
  logic [mwh_pkg::KeyW-1:0]  plo4_full;

  assign plo4_full = mwh_pkg::KeyW'(key_rd[mwh_pkg::AccWords][mwh_pkg::HalfW-1:0])
                     * mwh_pkg::KeyW'(msg1_q);

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      sd2_q <= sd1_q;
      for (int i = 0; i < mwh_pkg::AccWords; i++) begin
        plo_q[i] <= mwh_pkg::KeyW'(key_rd[i][mwh_pkg::HalfW-1:0])
                    * mwh_pkg::KeyW'(msg1_q);
        phi_q[i] <= mwh_pkg::KeyW'(key_rd[i][mwh_pkg::KeyW-1:mwh_pkg::HalfW])
                    * mwh_pkg::KeyW'(msg1_q);
      end
      plo4_q <= plo4_full[mwh_pkg::KeyW-1:mwh_pkg::HalfW];
    end
  end

  // stage 3: low 64 bits of key times word, and the carry-correction terms
  logic [mwh_pkg::KeyW-1:0]  base_q [mwh_pkg::AccWords];
  logic [mwh_pkg::HalfW-1:0] addv_q [mwh_pkg::AccWords];

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      sd3_q <= sd2_q;
      for (int i = 0; i < mwh_pkg::AccWords; i++) begin
        base_q[i] <= plo_q[i] + {phi_q[i][mwh_pkg::HalfW-1:0], {mwh_pkg::HalfW{1'b0}}};
      end
      addv_q[0] <= plo4_q;
      for (int i = 1; i < mwh_pkg::AccWords; i++) begin
        addv_q[i] <= phi_q[i-1][mwh_pkg::KeyW-1:mwh_pkg::HalfW];
      end
    end
  end

  // stage 4: both carry-in variants of each word, with carry out
  logic [mwh_pkg::KeyW:0] s0_q [mwh_pkg::AccWords];
  logic [mwh_pkg::KeyW:0] s1_q [mwh_pkg::AccWords];

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      sd4_q <= sd3_q;
      for (int i = 0; i < mwh_pkg::AccWords; i++) begin
        s0_q[i] <= {1'b0, base_q[i]} + (mwh_pkg::KeyW + 1)'(addv_q[i]);
        s1_q[i] <= {1'b0, base_q[i]} + (mwh_pkg::KeyW + 1)'(addv_q[i])
                   + (mwh_pkg::KeyW + 1)'(1);
      end
    end
  end

  // carry select across the four words, then fold into the accumulator
  logic [mwh_pkg::KeyW-1:0] acc_q    [mwh_pkg::AccWords];
  logic [mwh_pkg::KeyW-1:0] shadow_q [mwh_pkg::AccWords];
  logic [mwh_pkg::KeyW-1:0] term     [mwh_pkg::AccWords];
  logic [mwh_pkg::KeyW-1:0] acc_new  [mwh_pkg::AccWords];
  logic                     cy;

  always_comb begin
    cy = 1'b0;
    for (int i = 0; i < mwh_pkg::AccWords; i++) begin
      term[i]    = cy ? s1_q[i][mwh_pkg::KeyW-1:0] : s0_q[i][mwh_pkg::KeyW-1:0];
      cy         = cy ? s1_q[i][mwh_pkg::KeyW] : s0_q[i][mwh_pkg::KeyW];
      acc_new[i] = (sd4_q.first ? shadow_q[i] : acc_q[i])
                   ^ (sd4_q.hen ? term[i] : '0);
    end
  end

  // accumulator, updated in item order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mwh_pkg::AccWords; i++) begin
        acc_q[i] <= '0;
      end
    end else if (drain4 && sd4_q.hash) begin
      for (int i = 0; i < mwh_pkg::AccWords; i++) begin
        acc_q[i] <= acc_new[i];
      end
    end
  end

  // copy of key words 0 to 3 for the accumulator start, kept in item order
  always_ff @(posedge clk_i) begin
    if (drain4 && sd4_q.kwr) begin
      shadow_q[sd4_q.kidx] <= sd4_q.kdata;
    end
  end

  // output register
  logic [mwh_pkg::KeyW-1:0] hash_q [mwh_pkg::AccWords];
  logic [mwh_pkg::PosW-1:0] cnt_q;
  logic                     ovf_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (drain4 && res4) begin
      mv_q <= 1'b1;
    end else if (m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain4 && res4) begin
      for (int i = 0; i < mwh_pkg::AccWords; i++) begin
        hash_q[i] <= acc_new[i];
      end
      cnt_q     <= sd4_q.pos;
      ovf_out_q <= sd4_q.ovf;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {{(mwh_pkg::MDataW - mwh_pkg::MUsedW){1'b0}}, ovf_out_q, cnt_q,
                          hash_q[3], hash_q[2], hash_q[1], hash_q[0]};

endmodule

[rtl/mwh_checker.sv]
`include "multilinear_word_hash_macros.svh"

module mwh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [mwh_pkg::MDataW-1:0] m_axis_tdata
);

  // a waiting result stays offered
  `MWH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // a waiting result keeps its payload
  `MWH_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

  // every result follows at least one hashed word
  `MWH_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[mwh_pkg::MCntLsb +: mwh_pkg::PosW] != '0, "word count of zero")

  // overflow only once the position has reached capacity
  `MWH_ASSERT_IMP(a_ovf_at_cap, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[mwh_pkg::MOvfLsb], m_axis_tdata[mwh_pkg::MCntLsb +: mwh_pkg::PosW] == mwh_pkg::PosW'(mwh_pkg::MaxWords), "overflow below capacity")

endmodule

bind multilinear_word_hash mwh_checker u_mwh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/mwh_tb_pkg.sv]
`timescale 1ns / 100ps

package mwh_tb_pkg;
  import mwh_pkg::*;

  // one item as it enters the slave side
  typedef struct {
    kind_e           kind;
    logic [AddrW-1:0] addr;
    logic [KeyW-1:0] kdata;
    logic [MsgW-1:0] msg;
    logic [VbW-1:0]  vb;
    logic            first;
    logic            last;
  } hash_item_t;

  // one finished hash as it leaves the master side
  typedef struct packed {
    logic [AccWords-1:0][KeyW-1:0] words;
    logic [PosW-1:0]               count;
    logic                          ovf;
  } hash_result_t;

  // mirrors the key store and accumulator, queues the hashes to come
  class hash_board;
    logic [KeyW-1:0] key_words [KeyDepth];
    logic [KeyW-1:0] acc [AccWords];
    int unsigned     pos;
    logic            ovf;
    hash_result_t    pending_hashes [$];
    int unsigned     errors;
    int unsigned     hashes_checked;
    int unsigned     overflow_hashes;

    function new();
      int i;
      for (i = 0; i < KeyDepth; i++) key_words[i] = '0;
      for (i = 0; i < AccWords; i++) acc[i] = '0;
      pos = 0;
      ovf = 1'b0;
      errors = 0;
      hashes_checked = 0;
      overflow_hashes = 0;
    endfunction

    function void note_item(input hash_item_t it);
      logic [MsgW-1:0]  keep;
      logic [KeyW-1:0]  m;
      logic [KeyW-1:0]  prev;
      logic [KeyW-1:0]  part [AccWords];
      logic [KeyW-1:0]  fold [AccWords];
      logic             carry;
      int unsigned      base;
      int               i;
      hash_result_t     res;

      // key write: only the store changes, writes past its end are dropped
      if (it.kind == KIND_KEY) begin
        if (it.addr < KeyDepth) key_words[it.addr] = it.kdata;
        return;
      end

      // start of a new hash
      if (it.first) begin
        for (i = 0; i < AccWords; i++) acc[i] = key_words[i];
        pos = 0;
        ovf = 1'b0;
      end

      // keep only the valid low bytes
      case (it.vb)
        3'd0: keep = '0;
        3'd1: keep = MsgMask1;
        3'd2: keep = MsgMask2;
        3'd3: keep = MsgMask3;
        default: keep = MsgMaskFull;
      endcase
      m = {{(KeyW-MsgW){1'b0}}, it.msg & keep};

      // product with approximate carries, folded into the accumulator
      if (pos < MaxWords) begin
        base = (pos + 1) * KeyStride;
        for (i = 0; i < AccWords; i++) part[i] = key_words[base + i] * m;
        fold[0] = ((key_words[base + 4] & {{HalfW{1'b0}}, MsgMaskFull}) * m) >> HalfW;
        for (i = 1; i < AccWords; i++) fold[i] = ((key_words[base + i - 1] >> HalfW) * m) >> HalfW;
        carry = 1'b0;
        for (i = 0; i < AccWords; i++) begin
          prev = part[i];
          if (carry) part[i] = part[i] + 1;
          part[i] = part[i] + fold[i];
          carry = (part[i] < prev);
        end
        for (i = 0; i < AccWords; i++) acc[i] = acc[i] ^ part[i];
        pos++;
      end else begin
        ovf = 1'b1;
      end

      // last word hands out the hash
      if (it.last) begin
        for (i = 0; i < AccWords; i++) res.words[i] = acc[i];
        res.count = pos[PosW-1:0];
        res.ovf = ovf;
        pending_hashes.push_back(res);
      end
    endfunction

    function void check_hash(input logic [MDataW-1:0] data);
      hash_result_t want;
      int           i;

      if (pending_hashes.size() == 0) begin
        $error("hash result with none outstanding: %h", data);
        errors++;
        return;
      end
      want = pending_hashes.pop_front();
      hashes_checked++;
      if (want.ovf) overflow_hashes++;

      for (i = 0; i < AccWords; i++) begin
        if (data[i*KeyW +: KeyW] !== want.words[i]) begin
          $error("hash_word%0d: expected %h, got %h", i, want.words[i], data[i*KeyW +: KeyW]);
          errors++;
        end
      end
      if (data[MCntLsb +: PosW] !== want.count) begin
        $error("word_count: expected %0d, got %0d", want.count, data[MCntLsb +: PosW]);
        errors++;
      end
      if (data[MOvfLsb] !== want.ovf) begin
        $error("overflow: expected %b, got %b", want.ovf, data[MOvfLsb]);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mwh_pkg::*;
  import mwh_tb_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // key_address, key_data, message_word, valid_bytes, first_word, zero pad
  logic [SDataW-1:0] s_axis_tdata = '0;
  // kind
  logic              s_axis_tuser = 1'b0;
  // last_word
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // hash_word0, hash_word1, hash_word2, hash_word3, word_count, overflow, zero pad
  logic [MDataW-1:0] m_axis_tdata;

  hash_board   board = new();
  hash_item_t  seen_item;
  bit          key_loaded [KeyDepth];
  int unsigned gen_pos = 0;
  int unsigned send_idle_hi = 12;
  int unsigned recv_idle_hi = 12;
  int unsigned items_sent = 0;
  int unsigned key_writes = 0;

  multilinear_word_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL multilinear_word_hash");
    $finish;
  end

  // accepted input items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen_item.kind  = kind_e'(s_axis_tuser);
      seen_item.addr  = s_axis_tdata[SAddrLsb +: AddrW];
      seen_item.kdata = s_axis_tdata[SKeyLsb +: KeyW];
      seen_item.msg   = s_axis_tdata[SMsgLsb +: MsgW];
      seen_item.vb    = s_axis_tdata[SVbLsb +: VbW];
      seen_item.first = s_axis_tdata[SFirstLsb];
      seen_item.last  = s_axis_tlast;
      board.note_item(seen_item);
    end
  end

  // accepted results are checked against the oldest expected hash
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_hash(m_axis_tdata);
  end

  // result side: random stalls, with stall-free stretches now and then
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(15) == 0) recv_idle_hi = ($urandom_range(2) == 0) ? 0 : 12;
      gap = $urandom_range(recv_idle_hi);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input hash_item_t it);
    logic [SDataW-1:0] d;
    int unsigned       gap;
    if ($urandom_range(39) == 0) send_idle_hi = ($urandom_range(2) == 0) ? 0 : 12;
    gap = $urandom_range(send_idle_hi);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    d = '0;
    d[SAddrLsb +: AddrW] = it.addr;
    d[SKeyLsb +: KeyW]   = it.kdata;
    d[SMsgLsb +: MsgW]   = it.msg;
    d[SVbLsb +: VbW]     = it.vb;
    d[SFirstLsb]         = it.first;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= it.kind;
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_key(input int unsigned addr, input logic [KeyW-1:0] data);
    hash_item_t it;
    // hash-only fields carry noise on key writes
    it.kind  = KIND_KEY;
    it.addr  = addr[AddrW-1:0];
    it.kdata = data;
    it.msg   = $urandom;
    it.vb    = VbW'($urandom_range(7));
    it.first = 1'($urandom_range(1));
    it.last  = 1'($urandom_range(1));
    send_item(it);
    if (addr < KeyDepth) key_loaded[addr] = 1'b1;
    key_writes++;
  endtask

  task automatic load_row(input int unsigned row);
    int unsigned j;
    for (j = 0; j < KeyStride; j++) begin
      if (!key_loaded[row*KeyStride + j]) write_key(row*KeyStride + j, {$urandom, $urandom});
    end
  endtask

  // hashes one word, loading its key row first so no unwritten key is read
  task automatic hash_word(input logic [MsgW-1:0] msg, input logic [VbW-1:0] vb,
                           input logic first, input logic last);
    hash_item_t  it;
    int unsigned p;
    p = first ? 0 : gen_pos;
    if (p < MaxWords) load_row(p + 1);
    it.kind  = KIND_HASH;
    it.addr  = AddrW'($urandom);
    it.kdata = {$urandom, $urandom};
    it.msg   = msg;
    it.vb    = vb;
    it.first = first;
    it.last  = last;
    send_item(it);
    gen_pos = (p < MaxWords) ? p + 1 : p;
  endtask

  // stimulus and end of run
  initial begin
    int unsigned i;
    int unsigned j;
    int unsigned len;
    int unsigned pick;
    int unsigned start_count;
    logic [MsgW-1:0] msg;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed words for the accumulator
    load_row(0);

    // last word without a start word continues from the cleared state
    hash_word($urandom, 3'd4, 1'b0, 1'b1);

    // all-ones keys and message push the carry through every word
    for (j = 0; j < KeyStride; j++) write_key(KeyStride + j, '1);
    for (j = 0; j < AccWords; j++) write_key(j, '1);
    hash_word(MsgMaskFull, 3'd4, 1'b1, 1'b1);
    for (j = 0; j < KeyStride; j++) write_key(KeyStride + j, '0);
    hash_word(MsgMaskFull, 3'd4, 1'b1, 1'b1);
    hash_word('0, 3'd4, 1'b1, 1'b1);
    for (j = 0; j < KeyStride; j++) write_key(KeyStride + j, {$urandom, $urandom});
    for (j = 0; j < AccWords; j++) write_key(j, {$urandom, $urandom});

    // every valid-byte count, the zero and oversize codes included
    for (j = 0; j < 8; j++) hash_word($urandom, j[VbW-1:0], j == 0, j == 7);

    // writes past the end of the key store are dropped
    write_key(KeyDepth, '1);
    write_key((1 << AddrW) - 1, '1);

    // a start word in the middle of a hash restarts it
    hash_word($urandom, 3'd4, 1'b1, 1'b0);
    hash_word($urandom, 3'd4, 1'b0, 1'b0);
    hash_word($urandom, 3'd4, 1'b1, 1'b1);
    hash_word(MsgMaskFull, 3'd4, 1'b0, 1'b1);

    // full capacity, then words beyond it set the overflow flag
    hash_word($urandom, VbW'($urandom_range(7)), 1'b1, 1'b0);
    for (i = 1; i < MaxWords - 1; i++) begin
      hash_word($urandom, VbW'($urandom_range(7)), 1'b0, 1'b0);
    end
    hash_word($urandom, VbW'($urandom_range(7)), 1'b0, 1'b1);
    hash_word($urandom, VbW'($urandom_range(7)), 1'b0, 1'b1);
    hash_word($urandom, VbW'($urandom_range(7)), 1'b0, 1'b0);
    hash_word($urandom, VbW'($urandom_range(7)), 1'b0, 1'b0);
    hash_word($urandom, VbW'($urandom_range(7)), 1'b0, 1'b1);
    hash_word($urandom, VbW'($urandom_range(7)), 1'b1, 1'b1);

    // random mix: mostly whole hashes, some key rewrites and loose words
    start_count = items_sent;
    while (items_sent - start_count < 450) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        j = $urandom_range(9);
        if (j < 4) i = $urandom_range(10*KeyStride - 1);
        else if (j < 9) i = $urandom_range(KeyDepth - 1);
        else i = $urandom_range((1 << AddrW) - 1, KeyDepth);
        write_key(i, ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom});
      end else if (pick < 88) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (j = 0; j < len; j++) begin
          msg = ($urandom_range(15) == 0) ? MsgMaskFull : $urandom;
          hash_word(msg, ($urandom_range(3) == 0) ? VbW'($urandom_range(7)) : 3'd4,
                    j == 0, j == len - 1);
        end
      end else begin
        hash_word($urandom, VbW'($urandom_range(7)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (board.pending_hashes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d items, %0d of them key writes", items_sent, key_writes);
    $display("%0d hashes compared, %0d flagged overflow", board.hashes_checked,
             board.overflow_hashes);
    if (board.errors == 0) begin
      $display("PASS multilinear_word_hash");
    end else begin
      $display("FAIL multilinear_word_hash");
    end
    $finish;
  end

endmodule
